@@ sv/pew_pkg.sv @@
// ----------------------------------------------------------------------------
// pew_pkg
// Shared sizes, codes and types of the paced EEPROM write queue.
// ----------------------------------------------------------------------------
package pew_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_BURST   = 64;
  localparam int SLOT_BYTES  = 64;

  localparam int SLOT_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int BIDX_W   = $clog2(SLOT_BYTES);
  localparam int SIZE_W   = 7;
  localparam int BADDR_W  = SLOT_W + BIDX_W;

  localparam int TYPE_W   = 2;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 2;
  localparam int GAP_W    = 8;

  typedef enum logic [TYPE_W-1:0] {
    REQ_PUSH    = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_SERVICE = 2'd2
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED   = 2'd0,
    ST_TOO_LONG   = 2'd1,
    ST_QUEUE_FULL = 2'd2
  } status_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_WRITE  = 1'b1
  } out_kind_t;

endpackage

@@ sv/paced_eeprom_write_queue.sv @@
// ----------------------------------------------------------------------------
// paced_eeprom_write_queue
// Queue of EEPROM page-write requests, released one at a time with a minimum
// tick gap between releases.
// ----------------------------------------------------------------------------
// Usage: an item transfers on a rising edge with start high and busy low.
// Push bytes, ticks and service checks that release nothing keep busy low.
// The push status appears on the out_ ports, with out_valid high, in the cycle
// after the final byte transfers. A service that releases a request of n bytes
// raises busy while it runs: the byte RAM read port streams one byte per cycle,
// and the bytes appear on consecutive cycles once the release registers and
// then the RAM read register have loaded, the last one flagged by out_write_end.
// Each result is shown for exactly one cycle and the receiver cannot stall it,
// so it must take every strobe. Write cfg_wdata with cfg_we while no release is
// in progress to set the minimum gap; the new value is registered before use.
// ----------------------------------------------------------------------------
module paced_eeprom_write_queue
  import pew_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // item channel
  input  logic                start,
  output logic                busy,
  input  logic [TYPE_W-1:0]   in_req_type,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic [DATA_W-1:0]   in_data_byte,
  input  logic                in_last_byte,
  // result channel
  output logic                out_valid,
  output logic                out_kind,
  output logic [STATUS_W-1:0] out_status,
  output logic [ADDR_W-1:0]   out_write_address,
  output logic [DATA_W-1:0]   out_write_data,
  output logic                out_write_end,
  // configuration
  input  logic                cfg_we,
  input  logic [GAP_W-1:0]    cfg_wdata
);

  // Per-slot request descriptors, read only at the head slot.
  logic [ADDR_W-1:0] req_addr_mem [QUEUE_DEPTH];
  logic [SIZE_W-1:0] req_size_mem [QUEUE_DEPTH];

  // Control state
  logic [GAP_W-1:0]  min_gap_r;
  logic [SLOT_W-1:0] head_r, tail_r;
  logic [QCNT_W-1:0] qcnt_r;
  logic [SIZE_W-1:0] asm_cnt_r;
  logic              asm_ovf_r;
  logic              blocked_r;
  logic [GAP_W-1:0]  tick_r;
  logic [GAP_W-1:0]  stamp_r;

  // Release sequencer
  logic              rel_active_r;
  logic [SLOT_W-1:0] rel_slot_r;
  logic [BIDX_W-1:0] rel_idx_r;
  logic [SIZE_W-1:0] rel_n_r;
  logic [ADDR_W-1:0] rel_addr_r;

  // Output stage
  logic                out_valid_r;
  logic                out_kind_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                rd_end_r;

  // Item decode
  logic       acc;
  logic       is_push, is_tick, is_service;
  logic       full;
  logic       first_byte;
  logic       blocked_eff;
  logic       in_range;
  logic       store_byte;
  logic       ovf_eff;
  logic [SIZE_W-1:0] cnt_after;
  logic [GAP_W-1:0]  gap;
  logic       rel_go;
  logic       rel_last;
  status_t    push_st;
  logic [SLOT_W-1:0] tail_inc, head_inc;

  // Byte RAM ports
  logic               ram_we;
  logic [BADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  assign busy       = rel_active_r;
  assign acc        = start && !busy;
  assign is_push    = acc && (in_req_type == REQ_PUSH);
  assign is_tick    = acc && (in_req_type == REQ_TICK);
  assign is_service = acc && (in_req_type == REQ_SERVICE);

  // Fullness is judged at the first byte of a run and again at each byte.
  assign full        = (qcnt_r == QCNT_W'(QUEUE_DEPTH));
  assign first_byte  = (asm_cnt_r == '0) && !asm_ovf_r;
  assign blocked_eff = first_byte ? full : blocked_r;
  assign in_range    = (asm_cnt_r < SIZE_W'(MAX_BURST));
  assign store_byte  = is_push && in_range && !blocked_eff && !full;
  assign ovf_eff     = asm_ovf_r || !in_range;
  assign cnt_after   = in_range ? (asm_cnt_r + SIZE_W'(1)) : asm_cnt_r;

  always_comb begin
    if (ovf_eff) begin
      push_st = ST_TOO_LONG;
    end else if (blocked_eff || full) begin
      push_st = ST_QUEUE_FULL;
    end else begin
      push_st = ST_ACCEPTED;
    end
  end

  assign tail_inc = (tail_r == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + SLOT_W'(1);
  assign head_inc = (head_r == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + SLOT_W'(1);

  // Release only with a request waiting and a wrapped gap above the minimum.
  assign gap      = tick_r - stamp_r;
  assign rel_go   = is_service && (qcnt_r != '0) && (gap > min_gap_r);
  assign rel_last = ({1'b0, rel_idx_r} == (rel_n_r - SIZE_W'(1)));

  assign ram_we    = store_byte;
  assign ram_waddr = {tail_r, asm_cnt_r[BIDX_W-1:0]};
  assign ram_raddr = {rel_slot_r, rel_idx_r};

  pew_byte_ram #(
    .AW (BADDR_W),
    .DW (DATA_W)
  ) u_byte_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_data_byte),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Descriptor writes on an accepted final byte.
  always_ff @(posedge clk) begin
    if (is_push && in_last_byte && (push_st == ST_ACCEPTED)) begin
      req_addr_mem[tail_r] <= in_address;
      req_size_mem[tail_r] <= cnt_after;
    end
  end

  // Payload registers of the release, no reset needed.
  always_ff @(posedge clk) begin
    if (rel_go) begin
      rel_slot_r <= head_r;
      rel_n_r    <= req_size_mem[head_r];
      rel_addr_r <= req_addr_mem[head_r];
    end
    out_status_r <= push_st;
    rd_end_r     <= rel_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r    <= GAP_W'(5);
      head_r       <= '0;
      tail_r       <= '0;
      qcnt_r       <= '0;
      asm_cnt_r    <= '0;
      asm_ovf_r    <= 1'b0;
      blocked_r    <= 1'b0;
      tick_r       <= '0;
      stamp_r      <= '0;
      rel_active_r <= 1'b0;
      rel_idx_r    <= '0;
      out_valid_r  <= 1'b0;
      out_kind_r   <= KIND_STATUS;
    end else begin
      if (cfg_we) begin
        min_gap_r <= cfg_wdata;
      end

      out_valid_r <= 1'b0;

      // Push: assemble the run, give status on the final byte.
      if (is_push) begin
        if (in_last_byte) begin
          asm_cnt_r   <= '0;
          asm_ovf_r   <= 1'b0;
          blocked_r   <= 1'b0;
          out_valid_r <= 1'b1;
          out_kind_r  <= KIND_STATUS;
          if (push_st == ST_ACCEPTED) begin
            tail_r <= tail_inc;
            qcnt_r <= qcnt_r + QCNT_W'(1);
          end
        end else begin
          asm_cnt_r <= cnt_after;
          asm_ovf_r <= ovf_eff;
          blocked_r <= blocked_eff;
        end
      end

      if (is_tick) begin
        tick_r <= tick_r + GAP_W'(1);
      end

      // Service: stamp, dequeue at once, then stream the slot.
      if (rel_go) begin
        stamp_r      <= tick_r;
        head_r       <= head_inc;
        qcnt_r       <= qcnt_r - QCNT_W'(1);
        rel_active_r <= 1'b1;
        rel_idx_r    <= '0;
      end

      // Each read cycle yields one byte on the next cycle.
      if (rel_active_r) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= KIND_WRITE;
        rel_idx_r   <= rel_idx_r + BIDX_W'(1);
        if (rel_last) begin
          rel_active_r <= 1'b0;
        end
      end
    end
  end

  // Drive the unused fields of each result kind to zero.
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_status        = (out_kind_r == KIND_STATUS) ? out_status_r : STATUS_W'(0);
  assign out_write_address = (out_kind_r == KIND_WRITE) ? rel_addr_r : '0;
  assign out_write_data    = (out_kind_r == KIND_WRITE) ? ram_rdata : '0;
  assign out_write_end     = (out_kind_r == KIND_WRITE) && rd_end_r;

  // Assertions
  a_status_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    is_push && in_last_byte |=> out_valid && (out_kind == KIND_STATUS))
    else $error("push final byte without status result");

  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rel_go |=> busy)
    else $error("release started without raising busy");

  a_no_write_during_release: assert property (@(posedge clk) disable iff (!rst_n)
    rel_active_r |-> !ram_we)
    else $error("byte RAM written during a release");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_release_stream: assert property (@(posedge clk) disable iff (!rst_n)
    rel_active_r |=> out_valid && (out_kind == KIND_WRITE))
    else $error("release read cycle without a byte result");

endmodule

@@ sv/pew_byte_ram.sv @@
// ----------------------------------------------------------------------------
// pew_byte_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pew_byte_ram #(
  parameter int AW = 9,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
